>>> hdl/ppt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg
// Types and constants shared by the pedometer and pulse tick unit and its
// channel interfaces.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_CM   = 1'd1;

  localparam logic [9:0] PULSE_LEVEL_RST = 10'd600;
  localparam logic [7:0] STRIDE_CM_RST   = 8'd60;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_PEDO     = 2'd1;
  localparam logic [1:0] MODE_HEART    = 2'd2;
  localparam logic [1:0] MODE_ROTATION = 2'd3;

  localparam logic [7:0] BTN1_HIGH = 8'd10;
  localparam logic [7:0] BTN2_LOW  = 8'd100;
  localparam logic [7:0] BTN2_HIGH = 8'd150;
  localparam logic [7:0] BTN3_LOW  = 8'd160;
  localparam logic [7:0] BTN3_HIGH = 8'd200;

  localparam logic [7:0]  SPEED_SCALE = 8'd100;
  localparam logic [15:0] RATE_NUMER  = 16'd6000;
  localparam logic [15:0] SAT16       = 16'hFFFF;

  typedef struct packed {
    logic [9:0] button_sample;
    logic [9:0] pulse_sample;
    logic       step_pin;
  } ppt_in_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        led;
    logic [15:0] step_total;
    logic [15:0] speed_cm_s;
    logic [23:0] distance_cm;
    logic [12:0] heart_rate_bpm;
    logic [15:0] beat_total;
  } ppt_out_t;

endpackage

>>> hdl/ppt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_in_if / ppt_out_if
// Valid/ready channels carrying tick items and result items.
// ----------------------------------------------------------------------------
interface ppt_in_if import ppt_pkg::*; ();
  logic    valid;
  logic    ready;
  ppt_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppt_out_if import ppt_pkg::*; ();
  logic     valid;
  logic     ready;
  ppt_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/pedometer_pulse_tick_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedometer_pulse_tick_unit
// Per-tick LED divider, ladder button debounce, step counter with speed and
// distance, and pulse beat counter with heart rate.
// ----------------------------------------------------------------------------
// One item is one 10 ms tick. The tick is taken in S_IDLE and its result
// is loaded into the output register from S_DONE, passing through S_DIV
// first when it needs a division (a step edge with a non-zero interval, or
// a pending beat): the speed and the heart rate share one restoring divider
// that resolves one quotient bit per cycle. The input is not ready from
// acceptance until the result has been loaded into the output register; a
// result still waiting to be taken holds off that load.
// ----------------------------------------------------------------------------
module pedometer_pulse_tick_unit import ppt_pkg::*; #(
  parameter int unsigned LED_DIVIDE   = 20,
  parameter int unsigned HISTORY_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ppt_in_if.sink                in_i,
  ppt_out_if.source             out_o
);

  localparam int unsigned HB = HISTORY_BITS;
  localparam int unsigned DW = (LED_DIVIDE > 1) ? $clog2(LED_DIVIDE) : 1;
  localparam logic [DW-1:0] DIV_LAST  = DW'(LED_DIVIDE - 1);
  localparam logic [HB-1:0] EDGE_PAT  = {{(HB - HB/2){1'b1}}, {(HB/2){1'b0}}};
  localparam logic [HB-1:0] BEAT_PAT  = {1'b0, {(HB-1){1'b1}}};
  localparam logic [HB-1:0] HIST_ONE  = HB'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [9:0]    pulse_level_q;
  logic [7:0]    stride_q;
  logic [DW-1:0] led_div_q, led_div_d;
  logic          led_q, led_d;
  logic [HB-1:0] btn_hist_q [3];
  logic [HB-1:0] btn_hist_d [3];
  logic [1:0]    mode_q, mode_d;
  logic [HB-1:0] step_hist_q, step_hist_d;
  logic [15:0]   step_cnt_q, step_cnt_d;
  logic [15:0]   step_ivl_q, step_ivl_d;
  logic [15:0]   speed_q, speed_d;
  logic [HB-1:0] pulse_hist_q, pulse_hist_d;
  logic [15:0]   beat_ticks_q, beat_ticks_d;
  logic          beat_pend_q, beat_pend_d;
  logic [15:0]   beat_cnt_q, beat_cnt_d;
  logic [12:0]   rate_q, rate_d;

  logic [15:0]   div_rem_q, div_rem_d;
  logic [15:0]   div_quo_q, div_quo_d;
  logic [15:0]   div_den_q, div_den_d;
  logic [3:0]    div_cnt_q, div_cnt_d;
  logic          div_rate_q, div_rate_d;

  logic          out_valid_q, out_valid_d;
  ppt_out_t      out_q;
  logic          out_load;

  logic          accept;
  logic [7:0]    v;
  logic [2:0]    btn;
  logic [2:0]    trig;
  logic [15:0]   ticks_inc;
  logic [16:0]   trial;
  logic          ge;
  logic [15:0]   quo_next;

  assign accept      = in_i.valid & in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign out_load    = (state_q == S_DONE) & (~out_valid_q | out_o.ready);

  assign v      = in_i.data.button_sample[9:2];
  assign btn[0] = ~(v < BTN1_HIGH);
  assign btn[1] = ~((v > BTN2_LOW) & (v < BTN2_HIGH));
  assign btn[2] = ~((v > BTN3_LOW) & (v < BTN3_HIGH));

  assign ticks_inc = (beat_ticks_q == SAT16) ? SAT16 : beat_ticks_q + 16'd1;

  // shared restoring divider step
  assign trial    = {div_rem_q, div_quo_q[15]};
  assign ge       = (trial >= {1'b0, div_den_q});
  assign quo_next = {div_quo_q[14:0], ge};

  always_comb begin
    state_d      = state_q;
    led_div_d    = led_div_q;
    led_d        = led_q;
    mode_d       = mode_q;
    step_hist_d  = step_hist_q;
    step_cnt_d   = step_cnt_q;
    step_ivl_d   = step_ivl_q;
    speed_d      = speed_q;
    pulse_hist_d = pulse_hist_q;
    beat_ticks_d = beat_ticks_q;
    beat_pend_d  = beat_pend_q;
    beat_cnt_d   = beat_cnt_q;
    rate_d       = rate_q;
    div_rem_d    = div_rem_q;
    div_quo_d    = div_quo_q;
    div_den_d    = div_den_q;
    div_cnt_d    = div_cnt_q;
    div_rate_d   = div_rate_q;
    out_valid_d  = out_valid_q;
    for (int i = 0; i < 3; i++) begin
      trig[i]        = (btn_hist_q[i] == EDGE_PAT);
      btn_hist_d[i]  = btn_hist_q[i];
    end

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DONE;
          if (led_div_q == DIV_LAST) begin
            led_div_d = '0;
            led_d     = ~led_q;
          end else begin
            led_div_d = led_div_q + DW'(1);
          end
          for (int i = 0; i < 3; i++) begin
            btn_hist_d[i] = {btn_hist_q[i][HB-2:0], btn[i]};
          end
          if (trig[0]) begin
            mode_d = MODE_PEDO;
          end else if (trig[1]) begin
            mode_d     = MODE_HEART;
            beat_cnt_d = '0;
          end else if (trig[2]) begin
            mode_d = MODE_ROTATION;
          end else if (mode_q == MODE_PEDO) begin
            if (step_hist_q == EDGE_PAT) begin
              step_cnt_d = (step_cnt_q == SAT16) ? SAT16 : step_cnt_q + 16'd1;
              if (step_ivl_q == '0) begin
                speed_d = SAT16;
              end else begin
                div_rem_d  = '0;
                div_quo_d  = 16'(stride_q) * 16'(SPEED_SCALE);
                div_den_d  = step_ivl_q;
                div_cnt_d  = 4'd15;
                div_rate_d = 1'b0;
                state_d    = S_DIV;
              end
              step_ivl_d = '0;
            end else begin
              step_ivl_d = (step_ivl_q == SAT16) ? SAT16 : step_ivl_q + 16'd1;
            end
            step_hist_d = {step_hist_q[HB-2:0], in_i.data.step_pin};
          end else if (mode_q == MODE_HEART) begin
            beat_ticks_d = ticks_inc;
            if (beat_pend_q) begin
              div_rem_d    = '0;
              div_quo_d    = RATE_NUMER;
              div_den_d    = ticks_inc;
              div_cnt_d    = 4'd15;
              div_rate_d   = 1'b1;
              state_d      = S_DIV;
              beat_pend_d  = 1'b0;
              beat_ticks_d = '0;
            end
            pulse_hist_d = {pulse_hist_q[HB-2:0],
                            (in_i.data.pulse_sample > pulse_level_q)};
            if ({pulse_hist_q[HB-2:0], (in_i.data.pulse_sample > pulse_level_q)}
                == BEAT_PAT) begin
              beat_cnt_d  = (beat_cnt_q == SAT16) ? SAT16 : beat_cnt_q + 16'd1;
              beat_pend_d = 1'b1;
            end
          end
        end
      end
      S_DIV: begin
        div_rem_d = ge ? 16'(trial - {1'b0, div_den_q}) : trial[15:0];
        div_quo_d = quo_next;
        div_cnt_d = div_cnt_q - 4'd1;
        if (div_cnt_q == 4'd0) begin
          state_d = S_DONE;
          if (div_rate_q) begin
            rate_d = quo_next[12:0];
          end else begin
            speed_d = quo_next;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pulse_level_q <= PULSE_LEVEL_RST;
      stride_q      <= STRIDE_CM_RST;
      led_div_q     <= '0;
      led_q         <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        btn_hist_q[i] <= HIST_ONE;
      end
      mode_q        <= MODE_IDLE;
      step_hist_q   <= HIST_ONE;
      step_cnt_q    <= '0;
      step_ivl_q    <= '0;
      speed_q       <= '0;
      pulse_hist_q  <= '0;
      beat_ticks_q  <= '0;
      beat_pend_q   <= 1'b0;
      beat_cnt_q    <= '0;
      rate_q        <= '0;
      div_cnt_q     <= '0;
      div_rate_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PULSE_LEVEL: pulse_level_q <= cfg_data_i;
          REG_STRIDE_CM:   stride_q      <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      led_div_q    <= led_div_d;
      led_q        <= led_d;
      for (int i = 0; i < 3; i++) begin
        btn_hist_q[i] <= btn_hist_d[i];
      end
      mode_q       <= mode_d;
      step_hist_q  <= step_hist_d;
      step_cnt_q   <= step_cnt_d;
      step_ivl_q   <= step_ivl_d;
      speed_q      <= speed_d;
      pulse_hist_q <= pulse_hist_d;
      beat_ticks_q <= beat_ticks_d;
      beat_pend_q  <= beat_pend_d;
      beat_cnt_q   <= beat_cnt_d;
      rate_q       <= rate_d;
      div_cnt_q    <= div_cnt_d;
      div_rate_q   <= div_rate_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    div_den_q <= div_den_d;
    if (out_load) begin
      out_q.mode           <= mode_q;
      out_q.led            <= led_q;
      out_q.step_total     <= step_cnt_q;
      out_q.speed_cm_s     <= speed_q;
      out_q.distance_cm    <= 24'(step_cnt_q) * 24'(stride_q);
      out_q.heart_rate_bpm <= rate_q;
      out_q.beat_total     <= beat_cnt_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input ready right after an accepted item");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the load step");

  a_div_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && (div_cnt_q == 4'd0) |=> state_q == S_DONE)
    else $error("divider did not finish after its last step");

  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_q <= RATE_NUMER[12:0])
    else $error("heart rate beyond its range");
`endif

endmodule
